FILE: hw/rtl/awu_pkg.sv
package awu_pkg;

    // store geometry
    localparam int NUM_WEIGHTS = 4096;
    localparam int ADDR_W      = $clog2(NUM_WEIGHTS);

    // datapath widths
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int BETA_W    = 17;
    localparam int CFG_IDX_W = 3;

    // shared divider: 48-bit dividend, 32-bit divisor, one quotient bit per cycle
    localparam int DIV_W     = 48;
    localparam int DVS_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // square root: radicand is a positive Q16.16 value shifted up by 16
    localparam int ROOT_W        = 47;
    localparam int LEAD_W        = $clog2(ROOT_W);
    localparam int GUESS_W       = 24;
    localparam int NEWTON_PASSES = 8;
    localparam int PASS_W        = $clog2(NEWTON_PASSES + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_FIRST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_SECOND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON_TERM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE    = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0]  LR_RESET  = 31'd66;
    localparam logic [BETA_W-1:0] B1_RESET  = 17'd58982;
    localparam logic [BETA_W-1:0] B2_RESET  = 17'd65470;
    localparam logic [CFG_W-1:0]  EPS_RESET = 31'd1;
    localparam logic [CFG_W-1:0]  DR_RESET  = 31'd0;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;

    typedef struct packed {
        logic [11:0]               elem_index;
        logic                      start_of_step;
        logic signed [DATA_W-1:0]  weight_in;
        logic signed [DATA_W-1:0]  grad_in;
    } awu_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  weight_out;
        logic                      saturated;
    } awu_out_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } div_rsp_t;

    // clamp to signed 32 bits, flag in the top bit
    function automatic logic [DATA_W:0] sat_wide(input logic signed [63:0] v);
        logic [DATA_W:0] r;
        if (v > 64'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -64'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[DATA_W-1:0]};
        return r;
    endfunction

    // Q16.16 product: round half up, floor shift
    function automatic logic [DATA_W:0] qmul_round(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + 64'sd32768) >>> 16;
        return sat_wide(r);
    endfunction

    function automatic logic [DATA_W:0] add_sat(input logic signed [DATA_W-1:0] a,
                                                input logic signed [DATA_W-1:0] b);
        logic signed [63:0] s;
        s = {{32{a[DATA_W-1]}}, a} + {{32{b[DATA_W-1]}}, b};
        return sat_wide(s);
    endfunction

    function automatic logic [DATA_W:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                                input logic signed [DATA_W-1:0] b);
        logic signed [63:0] s;
        s = {{32{a[DATA_W-1]}}, a} - {{32{b[DATA_W-1]}}, b};
        return sat_wide(s);
    endfunction

    // magnitude of a, scaled by 2^16, as divider dividend
    function automatic logic [DIV_W-1:0] div_mag(input logic signed [DATA_W-1:0] a);
        logic [DATA_W-1:0] m;
        m = a[DATA_W-1] ? (~a + 32'd1) : a;
        return {m, 16'b0};
    endfunction

    // apply sign to an unsigned quotient and clamp
    function automatic logic [DATA_W:0] div_fix(input logic [DIV_W-1:0] q, input logic neg);
        logic [DATA_W:0]   r;
        logic [DATA_W-1:0] n;
        n = ~q[DATA_W-1:0] + 32'd1;
        if (neg) begin
            if (q > 48'h0000_8000_0000)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, n};
        end
        else begin
            if (q > 48'h0000_7FFF_FFFF)
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, q[DATA_W-1:0]};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/awu_moment_ram.sv
module awu_moment_ram (
    input  logic                                clk,
    input  logic                                we,
    input  logic [awu_pkg::ADDR_W-1:0]          waddr,
    input  logic [awu_pkg::DATA_W-1:0]          wdata,
    input  logic                                re,
    input  logic [awu_pkg::ADDR_W-1:0]          raddr,
    output logic [awu_pkg::DATA_W-1:0]          rdata
);

    logic [awu_pkg::DATA_W-1:0] mem [awu_pkg::NUM_WEIGHTS];
    logic [awu_pkg::DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/awu_divider.sv
module awu_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  awu_pkg::div_req_t   req,
    output awu_pkg::div_rsp_t   rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [awu_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [awu_pkg::DIV_W-1:0]     quo_reg;
    logic [awu_pkg::DVS_W-1:0]     rem_reg;
    logic [awu_pkg::DVS_W-1:0]     dvs_reg;

    logic [awu_pkg::DVS_W:0]       rem_sh;
    logic [awu_pkg::DVS_W+1:0]     trial;
    logic                          qbit;

    // one restoring step per cycle
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[awu_pkg::DIV_W-1]};
        trial  = {1'b0, rem_sh} - {2'b0, dvs_reg};
        qbit   = ~trial[awu_pkg::DVS_W+1];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == awu_pkg::DIV_CNT_W'(awu_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? trial[awu_pkg::DVS_W-1:0] : rem_sh[awu_pkg::DVS_W-1:0];
            quo_reg <= {quo_reg[awu_pkg::DIV_W-2:0], qbit};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: hw/rtl/adam_weight_update_core.sv
// Fixed-point AdamW update, one weight per transfer. After reset the block sweeps both
// moment stores to zero, one entry per cycle; item_stall stays high in that time while
// register writes are taken as usual. One item is in flight at a time: the moment entry
// is read, updated through a shared 32x32 multiplier and written back before the next
// item is accepted, so no two accesses to an entry overlap. An item runs through fixed
// sequencing, a bias correction for each moment on the shared one-bit-per-cycle divider,
// a leading-one search and up to eight square-root Newton passes, the final quotient on
// the divider, its scaling by the learning rate and, when weight decay is on, the decay
// step. A finished result waits in the output register while the next item is accepted.
module adam_weight_update_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  awu_pkg::awu_in_t                  item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output awu_pkg::awu_out_t                 result,
    input  logic                              cfg_we,
    input  logic [awu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [awu_pkg::CFG_W-1:0]         cfg_data
);

    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_A       = 5'd2;
    localparam logic [4:0] S_B       = 5'd3;
    localparam logic [4:0] S_C       = 5'd4;
    localparam logic [4:0] S_D       = 5'd5;
    localparam logic [4:0] S_E       = 5'd6;
    localparam logic [4:0] S_F       = 5'd7;
    localparam logic [4:0] S_G       = 5'd8;
    localparam logic [4:0] S_H       = 5'd9;
    localparam logic [4:0] S_I       = 5'd10;
    localparam logic [4:0] S_MH      = 5'd11;
    localparam logic [4:0] S_MH_WAIT = 5'd12;
    localparam logic [4:0] S_VH      = 5'd13;
    localparam logic [4:0] S_VH_WAIT = 5'd14;
    localparam logic [4:0] S_SQ_INIT = 5'd15;
    localparam logic [4:0] S_SQ_LEAD = 5'd16;
    localparam logic [4:0] S_SQ_DIV  = 5'd17;
    localparam logic [4:0] S_SQ_WAIT = 5'd18;
    localparam logic [4:0] S_DEN     = 5'd19;
    localparam logic [4:0] S_UP      = 5'd20;
    localparam logic [4:0] S_UP_WAIT = 5'd21;
    localparam logic [4:0] S_UP_MUL  = 5'd22;
    localparam logic [4:0] S_UP_RES  = 5'd23;
    localparam logic [4:0] S_DC      = 5'd24;
    localparam logic [4:0] S_DC2     = 5'd25;
    localparam logic [4:0] S_DC3     = 5'd26;
    localparam logic [4:0] S_DC4     = 5'd27;
    localparam logic [4:0] S_DC5     = 5'd28;
    localparam logic [4:0] S_TH      = 5'd29;
    localparam logic [4:0] S_DONE    = 5'd30;

    // control state
    logic [4:0]                      state_reg;
    logic [4:0]                      state_next;
    logic [awu_pkg::ADDR_W-1:0]      clr_addr_reg;
    logic                            result_valid_reg;
    logic [awu_pkg::PASS_W-1:0]      pass_reg;

    // configuration and beta powers
    logic [awu_pkg::CFG_W-1:0]       lr_reg;
    logic [awu_pkg::BETA_W-1:0]      b1_reg;
    logic [awu_pkg::BETA_W-1:0]      b2_reg;
    logic [awu_pkg::CFG_W-1:0]       eps_reg;
    logic [awu_pkg::CFG_W-1:0]       dr_reg;
    logic signed [31:0]              bp1_reg;
    logic signed [31:0]              bp2_reg;

    // item payload and intermediates
    logic [awu_pkg::ADDR_W-1:0]      idx_reg;
    logic                            step_reg;
    logic signed [31:0]              theta_reg;
    logic signed [31:0]              grad_reg;
    logic signed [31:0]              mom1_reg;
    logic signed [31:0]              mom2_reg;
    logic signed [31:0]              bm_reg;
    logic signed [31:0]              og_reg;
    logic signed [31:0]              gg_reg;
    logic signed [31:0]              bv_reg;
    logic signed [31:0]              ogg_reg;
    logic signed [31:0]              m_reg;
    logic signed [31:0]              v_reg;
    logic signed [31:0]              omb1t_reg;
    logic signed [31:0]              omb2t_reg;
    logic signed [31:0]              mh_reg;
    logic signed [31:0]              vh_reg;
    logic signed [31:0]              den_reg;
    logic signed [31:0]              tmp_reg;
    logic signed [31:0]              upd_reg;
    logic [awu_pkg::ROOT_W-1:0]      root_reg;
    logic [awu_pkg::LEAD_W-1:0]      lead_reg;
    logic [awu_pkg::GUESS_W-1:0]     guess_reg;
    logic                            div_neg_reg;
    logic                            sat_reg;
    logic signed [63:0]              prod_reg;
    awu_pkg::awu_out_t               result_reg;

    // combinational helpers
    logic                            accept;
    logic signed [31:0]              lr_s;
    logic signed [31:0]              dr_s;
    logic signed [31:0]              eps_s;
    logic signed [31:0]              b1_s;
    logic signed [31:0]              b2_s;
    logic signed [31:0]              omb1;
    logic signed [31:0]              omb2;
    logic signed [31:0]              mul_a;
    logic signed [31:0]              mul_b;
    logic [32:0]                     rq;
    logic [32:0]                     m_sum;
    logic [32:0]                     v_sum;
    logic [32:0]                     omb1t_s;
    logic [32:0]                     omb2t_s;
    logic [32:0]                     div_q;
    logic [32:0]                     den_s;
    logic [32:0]                     dc_s;
    logic [32:0]                     th_s;
    logic signed [32:0]              gsum;
    logic [awu_pkg::DIV_W:0]         nsum;
    logic [awu_pkg::DIV_W-1:0]       ng;
    logic [6:0]                      lsum;
    logic                            out_free;
    logic                            m_we;
    logic                            v_we;
    logic [awu_pkg::ADDR_W-1:0]      mem_waddr;
    logic [31:0]                     m_wdata;
    logic [31:0]                     v_wdata;
    logic [31:0]                     m_rdata;
    logic [31:0]                     v_rdata;
    awu_pkg::div_req_t               div_req;
    awu_pkg::div_rsp_t               div_rsp;

    assign accept   = item_valid && (state_reg == S_IDLE);
    assign out_free = !result_valid_reg || !result_stall;

    // operand views of the registers
    always_comb
    begin
        lr_s  = {1'b0, lr_reg};
        dr_s  = {1'b0, dr_reg};
        eps_s = {1'b0, eps_reg};
        b1_s  = {15'b0, b1_reg};
        b2_s  = {15'b0, b2_reg};
        omb1  = awu_pkg::Q_ONE - b1_s;
        omb2  = awu_pkg::Q_ONE - b2_s;
    end

    // saturating arithmetic around the stored values
    always_comb
    begin
        rq      = awu_pkg::qmul_round(prod_reg);
        m_sum   = awu_pkg::add_sat(bm_reg, og_reg);
        v_sum   = awu_pkg::add_sat(bv_reg, ogg_reg);
        omb1t_s = awu_pkg::sub_sat(awu_pkg::Q_ONE, bp1_reg);
        omb2t_s = awu_pkg::sub_sat(awu_pkg::Q_ONE, bp2_reg);
        div_q   = awu_pkg::div_fix(div_rsp.quotient, div_neg_reg);
        den_s   = awu_pkg::add_sat({8'b0, guess_reg}, eps_s);
        dc_s    = awu_pkg::sub_sat(theta_reg, tmp_reg);
        th_s    = awu_pkg::sub_sat(theta_reg, upd_reg);
        gsum    = {item.grad_in[31], item.grad_in} + 33'sd128;
        nsum    = {25'b0, guess_reg} + {1'b0, div_rsp.quotient};
        ng      = nsum[awu_pkg::DIV_W:1];
        lsum    = {1'b0, lead_reg} + 7'd1;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_A:      begin mul_a = bp1_reg; mul_b = b1_s;     end
            S_B:      begin mul_a = bp2_reg; mul_b = b2_s;     end
            S_C:      begin mul_a = b1_s;    mul_b = mom1_reg; end
            S_D:      begin mul_a = omb1;    mul_b = grad_reg; end
            S_E:      begin mul_a = grad_reg; mul_b = grad_reg; end
            S_F:      begin mul_a = b2_s;    mul_b = mom2_reg; end
            S_G:      begin mul_a = omb2;    mul_b = gg_reg;   end
            S_UP_MUL: begin mul_a = lr_s;    mul_b = tmp_reg;  end
            S_DC:     begin mul_a = lr_s;    mul_b = dr_s;     end
            S_DC3:    begin mul_a = tmp_reg; mul_b = theta_reg; end
            default:  ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == awu_pkg::ADDR_W'(awu_pkg::NUM_WEIGHTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid)
                    state_next = S_A;
            end
            S_A: state_next = S_B;
            S_B: state_next = S_C;
            S_C: state_next = S_D;
            S_D: state_next = S_E;
            S_E: state_next = S_F;
            S_F: state_next = S_G;
            S_G: state_next = S_H;
            S_H: state_next = S_I;
            S_I: state_next = S_MH;
            S_MH:
            begin
                if (omb1t_reg > 32'sd0)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = awu_pkg::div_mag(m_reg);
                    div_req.divisor  = omb1t_reg;
                    state_next       = S_MH_WAIT;
                end
                else
                    state_next = S_VH;
            end
            S_MH_WAIT:
            begin
                if (div_rsp.done)
                    state_next = S_VH;
            end
            S_VH:
            begin
                if (omb2t_reg > 32'sd0)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = awu_pkg::div_mag(v_reg);
                    div_req.divisor  = omb2t_reg;
                    state_next       = S_VH_WAIT;
                end
                else
                    state_next = S_SQ_INIT;
            end
            S_VH_WAIT:
            begin
                if (div_rsp.done)
                    state_next = S_SQ_INIT;
            end
            S_SQ_INIT:
            begin
                if (vh_reg > 32'sd0)
                    state_next = S_SQ_LEAD;
                else
                    state_next = S_DEN;
            end
            S_SQ_LEAD:
            begin
                if (root_reg[lead_reg])
                    state_next = S_SQ_DIV;
            end
            S_SQ_DIV:
            begin
                if (pass_reg == awu_pkg::PASS_W'(awu_pkg::NEWTON_PASSES))
                    state_next = S_DEN;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, root_reg};
                    div_req.divisor  = {8'b0, guess_reg};
                    state_next       = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (ng >= {24'b0, guess_reg})
                        state_next = S_DEN;
                    else
                        state_next = S_SQ_DIV;
                end
            end
            S_DEN: state_next = S_UP;
            S_UP:
            begin
                if (den_reg > 32'sd0)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = awu_pkg::div_mag(mh_reg);
                    div_req.divisor  = den_reg;
                    state_next       = S_UP_WAIT;
                end
                else
                    state_next = S_DC;
            end
            S_UP_WAIT:
            begin
                if (div_rsp.done)
                    state_next = S_UP_MUL;
            end
            S_UP_MUL: state_next = S_UP_RES;
            S_UP_RES: state_next = S_DC;
            S_DC:
            begin
                if (dr_reg != '0)
                    state_next = S_DC2;
                else
                    state_next = S_TH;
            end
            S_DC2: state_next = S_DC3;
            S_DC3: state_next = S_DC4;
            S_DC4: state_next = S_DC5;
            S_DC5: state_next = S_TH;
            S_TH:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // moment store write ports: clearing sweep, then write-back
    always_comb
    begin
        m_we      = (state_reg == S_CLEAR) || (state_reg == S_G);
        v_we      = (state_reg == S_CLEAR) || (state_reg == S_I);
        mem_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : idx_reg;
        m_wdata   = (state_reg == S_CLEAR) ? 32'd0 : m_sum[31:0];
        v_wdata   = (state_reg == S_CLEAR) ? 32'd0 : v_sum[31:0];
    end

    awu_moment_ram u_first_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (mem_waddr),
        .wdata (m_wdata),
        .re    (accept),
        .raddr (item.elem_index[awu_pkg::ADDR_W-1:0]),
        .rdata (m_rdata)
    );

    awu_moment_ram u_second_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (mem_waddr),
        .wdata (v_wdata),
        .re    (accept),
        .raddr (item.elem_index[awu_pkg::ADDR_W-1:0]),
        .rdata (v_rdata)
    );

    awu_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // control registers, configuration and beta powers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
            pass_reg         <= '0;
            lr_reg           <= awu_pkg::LR_RESET;
            b1_reg           <= awu_pkg::B1_RESET;
            b2_reg           <= awu_pkg::B2_RESET;
            eps_reg          <= awu_pkg::EPS_RESET;
            dr_reg           <= awu_pkg::DR_RESET;
            bp1_reg          <= awu_pkg::Q_ONE;
            bp2_reg          <= awu_pkg::Q_ONE;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;

            // output slot
            if (state_reg == S_DONE && out_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            // newton pass count
            if (state_reg == S_SQ_LEAD)
                pass_reg <= '0;
            else if (state_reg == S_SQ_WAIT && div_rsp.done)
                pass_reg <= pass_reg + 1'b1;

            // beta power advance on a step start
            if (state_reg == S_B && step_reg)
                bp1_reg <= rq[31:0];
            if (state_reg == S_C && step_reg)
                bp2_reg <= rq[31:0];

            if (cfg_we)
            begin
                unique case (cfg_index)
                    awu_pkg::REG_LEARNING_RATE: lr_reg  <= cfg_data;
                    awu_pkg::REG_BETA_FIRST:    b1_reg  <= cfg_data[awu_pkg::BETA_W-1:0];
                    awu_pkg::REG_BETA_SECOND:   b2_reg  <= cfg_data[awu_pkg::BETA_W-1:0];
                    awu_pkg::REG_EPSILON_TERM:  eps_reg <= cfg_data;
                    awu_pkg::REG_DECAY_RATE:    dr_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    idx_reg   <= item.elem_index[awu_pkg::ADDR_W-1:0];
                    step_reg  <= item.start_of_step;
                    theta_reg <= item.weight_in;
                    grad_reg  <= {{7{gsum[32]}}, gsum[32:8]};
                    sat_reg   <= 1'b0;
                end
            end
            S_A:
            begin
                mom1_reg <= m_rdata;
                mom2_reg <= v_rdata;
            end
            S_B, S_C:
            begin
                if (step_reg)
                    sat_reg <= sat_reg | rq[32];
            end
            S_D:
            begin
                bm_reg  <= rq[31:0];
                sat_reg <= sat_reg | rq[32];
            end
            S_E:
            begin
                og_reg  <= rq[31:0];
                sat_reg <= sat_reg | rq[32];
            end
            S_F:
            begin
                gg_reg  <= rq[31:0];
                sat_reg <= sat_reg | rq[32];
            end
            S_G:
            begin
                m_reg   <= m_sum[31:0];
                bv_reg  <= rq[31:0];
                sat_reg <= sat_reg | rq[32] | m_sum[32];
            end
            S_H:
            begin
                ogg_reg <= rq[31:0];
                sat_reg <= sat_reg | rq[32];
            end
            S_I:
            begin
                v_reg     <= v_sum[31:0];
                omb1t_reg <= omb1t_s[31:0];
                omb2t_reg <= omb2t_s[31:0];
                sat_reg   <= sat_reg | v_sum[32] | omb1t_s[32] | omb2t_s[32];
            end
            S_MH:
            begin
                div_neg_reg <= m_reg[31];
                mh_reg      <= m_reg;
            end
            S_MH_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mh_reg  <= div_q[31:0];
                    sat_reg <= sat_reg | div_q[32];
                end
            end
            S_VH:
            begin
                div_neg_reg <= v_reg[31];
                vh_reg      <= v_reg;
            end
            S_VH_WAIT:
            begin
                if (div_rsp.done)
                begin
                    vh_reg  <= div_q[31:0];
                    sat_reg <= sat_reg | div_q[32];
                end
            end
            S_SQ_INIT:
            begin
                root_reg  <= {vh_reg[30:0], 16'b0};
                lead_reg  <= awu_pkg::LEAD_W'(awu_pkg::ROOT_W - 1);
                guess_reg <= '0;
            end
            S_SQ_LEAD:
            begin
                // leading one search, one bit per cycle
                if (root_reg[lead_reg])
                    guess_reg <= awu_pkg::GUESS_W'(1) << lsum[5:1];
                else
                    lead_reg <= lead_reg - 1'b1;
            end
            S_SQ_WAIT:
            begin
                if (div_rsp.done && (ng < {24'b0, guess_reg}))
                    guess_reg <= ng[awu_pkg::GUESS_W-1:0];
            end
            S_DEN:
            begin
                den_reg <= den_s[31:0];
                sat_reg <= sat_reg | den_s[32];
            end
            S_UP:
            begin
                div_neg_reg <= mh_reg[31];
                upd_reg     <= '0;
            end
            S_UP_WAIT:
            begin
                if (div_rsp.done)
                begin
                    tmp_reg <= div_q[31:0];
                    sat_reg <= sat_reg | div_q[32];
                end
            end
            S_UP_RES:
            begin
                upd_reg <= rq[31:0];
                sat_reg <= sat_reg | rq[32];
            end
            S_DC2, S_DC4:
            begin
                tmp_reg <= rq[31:0];
                sat_reg <= sat_reg | rq[32];
            end
            S_DC5:
            begin
                theta_reg <= dc_s[31:0];
                sat_reg   <= sat_reg | dc_s[32];
            end
            S_TH:
            begin
                theta_reg <= th_s[31:0];
                sat_reg   <= sat_reg | th_s[32];
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    result_reg.weight_out <= theta_reg;
                    result_reg.saturated  <= sat_reg;
                end
            end
            default: ;
        endcase
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // no moment write-back while waiting for an item
    ap_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(m_we || v_we))
        else $error("moment store written while idle");

    // a division is only started on a free divider
    ap_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("division started while divider busy");

    // newton loop is bounded
    ap_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pass_reg <= awu_pkg::PASS_W'(awu_pkg::NEWTON_PASSES))
        else $error("newton pass count out of range");

    // newton divisor never zero
    ap_guess_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ_DIV) |-> (guess_reg != '0))
        else $error("zero newton guess");

endmodule
